// ----- src/gravity_pair_force_unit_assert.svh -----
// Assertion macros for the gravity pair force unit checker.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef GRAVITY_PAIR_FORCE_UNIT_ASSERT_SVH
`define GRAVITY_PAIR_FORCE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GPF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gravity pair force check failed");

// Next-cycle implication, disabled during reset.
`define GPF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gravity pair force check failed");

`endif

// ----- src/gpf_pkg.sv -----
// Shared types, widths and register codes for the gravity pair force unit.
// Used by every module of the block; depends on nothing.
package gpf_pkg;

    localparam int COORD_W     = 32;
    localparam int MASS_W      = 32;
    localparam int CFG_W       = 32;
    localparam int FORCE_W     = 48;
    localparam int CFG_IDX_W   = 2;
    localparam int EXTRA_BITS  = 16;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int ABS_W       = COORD_W;
    localparam int SQR_W       = 2 * ABS_W;
    localparam int SUM_W       = SQR_W + 1;
    localparam int RAD_W       = SUM_W + 2 * EXTRA_BITS;
    localparam int ROOT_W      = (RAD_W + 1) / 2;
    localparam int GM_W        = CFG_W + MASS_W;
    localparam int K_W         = GM_W + MASS_W;
    localparam int DEN_W       = SUM_W + ROOT_W;
    localparam int PROD_W      = K_W + ABS_W;
    localparam int NUM_W       = PROD_W + EXTRA_BITS;
    localparam int MAG_W       = FORCE_W - 1;
    localparam int CMP_W       = DEN_W + MAG_W;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int DIV_STAGES  = MAG_W + 1;
    localparam int GPF_LATENCY = SQRT_STAGES + DIV_STAGES + 7;

    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 2'd1;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic [MASS_W-1:0]         first_mass;
        logic [MASS_W-1:0]         second_mass;
        logic                      one_way;
    } gpf_in_t;

    typedef struct packed {
        logic signed [FORCE_W-1:0] first_force_x;
        logic signed [FORCE_W-1:0] first_force_y;
        logic signed [FORCE_W-1:0] second_force_x;
        logic signed [FORCE_W-1:0] second_force_y;
        logic                      second_applies;
        logic                      too_close;
        logic                      saturated;
    } gpf_out_t;

    typedef struct packed {
        logic [SUM_W-1:0] s;
        logic [K_W-1:0]   k;
        logic [ABS_W-1:0] adx;
        logic [ABS_W-1:0] ady;
        logic             px;
        logic             py;
        logic             one_way;
    } gpf_sq_side_t;

    typedef struct packed {
        logic kill;
        logic close;
        logic px;
        logic py;
        logic one_way;
    } gpf_div_side_t;

endpackage

// ----- src/gpf_isqrt_pipe.sv -----
// Pipelined integer square root, one result bit per stage.
// Uses gpf_pkg for widths and the sideband type carried with each beat.
module gpf_isqrt_pipe (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [gpf_pkg::RAD_W-1:0] rad,
    input  gpf_pkg::gpf_sq_side_t in_side,
    output logic                 out_valid,
    output logic [gpf_pkg::ROOT_W-1:0] root,
    output gpf_pkg::gpf_sq_side_t out_side
);
    import gpf_pkg::*;

    localparam int TRIAL_W = RAD_W + 1;

    logic               v_reg    [SQRT_STAGES];
    logic [RAD_W-1:0]   rem_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0]  root_reg [SQRT_STAGES];
    gpf_sq_side_t       side_reg [SQRT_STAGES];

    for (genvar j = 0; j < SQRT_STAGES; j++)
    begin : g_stage
        localparam int B = ROOT_W - 1 - j;
        logic               v_in;
        logic [RAD_W-1:0]   rem_in;
        logic [ROOT_W-1:0]  root_in;
        gpf_sq_side_t       side_in;
        logic [TRIAL_W-1:0] trial;
        logic               fits;

        if (j == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = rad;
            assign root_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign v_in    = v_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        assign trial = (TRIAL_W'(root_in) << (B + 1)) + (TRIAL_W'(1) << (2 * B));
        assign fits  = {1'b0, rem_in} >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else
            begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= fits ? (rem_in - trial[RAD_W-1:0]) : rem_in;
            root_reg[j] <= fits ? (root_in | (ROOT_W'(1) << B)) : root_in;
            side_reg[j] <= side_in;
        end
    end

    assign out_valid = v_reg[SQRT_STAGES-1];
    assign root      = root_reg[SQRT_STAGES-1];
    assign out_side  = side_reg[SQRT_STAGES-1];

endmodule

// ----- src/gpf_div_pipe.sv -----
// Pipelined two-lane restoring divider with a saturating quotient.
// Uses gpf_pkg for widths, the clip value and the sideband type.
module gpf_div_pipe (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [gpf_pkg::NUM_W-1:0] num_x,
    input  logic [gpf_pkg::NUM_W-1:0] num_y,
    input  logic [gpf_pkg::DEN_W-1:0] den,
    input  gpf_pkg::gpf_div_side_t    in_side,
    output logic                      out_valid,
    output logic [gpf_pkg::MAG_W-1:0] mag_x,
    output logic [gpf_pkg::MAG_W-1:0] mag_y,
    output logic                      over_x,
    output logic                      over_y,
    output gpf_pkg::gpf_div_side_t    out_side
);
    import gpf_pkg::*;

    logic              v_reg    [DIV_STAGES];
    logic [DEN_W-1:0]  den_reg  [DIV_STAGES];
    gpf_div_side_t     side_reg [DIV_STAGES];
    logic [NUM_W-1:0]  rem_reg  [DIV_STAGES][2];
    logic [MAG_W-1:0]  q_reg    [DIV_STAGES][2];
    logic              over_reg [DIV_STAGES][2];
    logic [NUM_W-1:0]  num_in   [2];

    assign num_in[0] = num_x;
    assign num_in[1] = num_y;

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_stage
        logic v_in;

        if (j == 0)
        begin : g_first
            assign v_in = in_valid;
            always_ff @(posedge clk)
            begin
                den_reg[j]  <= den;
                side_reg[j] <= in_side;
            end
            for (genvar l = 0; l < 2; l++)
            begin : g_lane
                always_ff @(posedge clk)
                begin
                    rem_reg[j][l]  <= num_in[l];
                    q_reg[j][l]    <= '0;
                    over_reg[j][l] <= CMP_W'(num_in[l]) >= (CMP_W'(den) << MAG_W);
                end
            end
        end
        else
        begin : g_iter
            localparam int B = MAG_W - j;
            logic [CMP_W-1:0] dshift;

            assign v_in   = v_reg[j-1];
            assign dshift = CMP_W'(den_reg[j-1]) << B;

            always_ff @(posedge clk)
            begin
                den_reg[j]  <= den_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
            for (genvar l = 0; l < 2; l++)
            begin : g_lane
                logic [CMP_W-1:0] diff;
                logic             ge;
                logic [MAG_W-1:0] q_next;

                assign diff = CMP_W'(rem_reg[j-1][l]) - dshift;
                assign ge   = CMP_W'(rem_reg[j-1][l]) >= dshift;

                always_comb
                begin
                    q_next    = q_reg[j-1][l];
                    q_next[B] = ge;
                end

                always_ff @(posedge clk)
                begin
                    rem_reg[j][l]  <= ge ? diff[NUM_W-1:0] : rem_reg[j-1][l];
                    q_reg[j][l]    <= q_next;
                    over_reg[j][l] <= over_reg[j-1][l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else
            begin
                v_reg[j] <= v_in;
            end
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];
    assign over_x    = over_reg[DIV_STAGES-1][0];
    assign over_y    = over_reg[DIV_STAGES-1][1];
    assign mag_x     = over_x ? MAG_MAX : q_reg[DIV_STAGES-1][0];
    assign mag_y     = over_y ? MAG_MAX : q_reg[DIV_STAGES-1][1];

endmodule

// ----- src/gravity_pair_force_unit.sv -----
// Newtonian gravity force between one pair of 2D bodies, fully pipelined.
// Depends on gpf_pkg, gpf_isqrt_pipe and gpf_div_pipe.
// Throughput: one pair per cycle; the 49-stage root and 48-stage divider are fully pipelined.
// Reset clears every valid bit and restores G and the minimum distance; busy is high only in reset.
// There is no output backpressure: each result is shown for exactly one cycle.
module gravity_pair_force_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  gpf_pkg::gpf_in_t              pair,
    output logic                          done,
    output gpf_pkg::gpf_out_t             forces,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gpf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gpf_pkg::CFG_W-1:0]     cfg_data
);
    import gpf_pkg::*;

    localparam logic [CFG_W-1:0] GRAV_RST = CFG_W'(64'd1 << FRAC_BITS);
    localparam logic [CFG_W-1:0] MIN_RST  = CFG_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam int S_LO_W = SUM_W - SUM_W / 2;
    localparam int R_LO_W = ROOT_W - ROOT_W / 2;
    localparam int S_HI_W = SUM_W - S_LO_W;
    localparam int R_HI_W = ROOT_W - R_LO_W;

    logic [CFG_W-1:0] gravity_reg;
    logic [CFG_W-1:0] min_dist_reg;
    logic             accept;

    assign busy      = ~rst_n;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg  <= GRAV_RST;
            min_dist_reg <= MIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GRAVITY:  gravity_reg  <= cfg_data;
                CFG_MIN_DIST: min_dist_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Stage 1: separation.
    logic                     v1_reg;
    logic signed [DIFF_W-1:0] dx1_reg, dy1_reg;
    logic [MASS_W-1:0]        m1_1_reg, m2_1_reg;
    logic                     ow1_reg;

    // Stage 2: magnitudes, signs and G*m1.
    logic              v2_reg;
    logic [ABS_W-1:0]  adx2_reg, ady2_reg;
    logic              px2_reg, py2_reg, ow2_reg;
    logic [GM_W-1:0]   gm2_reg;
    logic [MASS_W-1:0] m2_2_reg;
    logic [DIFF_W-1:0] absx2_next, absy2_next;

    // Stage 3: squares and partial products of k.
    logic             v3_reg;
    logic [SQR_W-1:0] sqx3_reg, sqy3_reg;
    logic [SQR_W-1:0] kl3_reg, kh3_reg;
    logic [ABS_W-1:0] adx3_reg, ady3_reg;
    logic             px3_reg, py3_reg, ow3_reg;

    // Stage 4: squared length and k, into the root pipeline.
    logic         v4_reg;
    gpf_sq_side_t side4_reg;

    logic              sq_valid;
    logic [ROOT_W-1:0] rq;
    gpf_sq_side_t      sq_side;

    assign absx2_next = dx1_reg[DIFF_W-1] ? (DIFF_W'(0) - dx1_reg) : dx1_reg;
    assign absy2_next = dy1_reg[DIFF_W-1] ? (DIFF_W'(0) - dy1_reg) : dy1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx1_reg  <= {pair.second_x[COORD_W-1], pair.second_x}
                  - {pair.first_x[COORD_W-1], pair.first_x};
        dy1_reg  <= {pair.second_y[COORD_W-1], pair.second_y}
                  - {pair.first_y[COORD_W-1], pair.first_y};
        m1_1_reg <= pair.first_mass;
        m2_1_reg <= pair.second_mass;
        ow1_reg  <= pair.one_way;

        adx2_reg <= absx2_next[ABS_W-1:0];
        ady2_reg <= absy2_next[ABS_W-1:0];
        px2_reg  <= !dx1_reg[DIFF_W-1] && (dx1_reg != '0);
        py2_reg  <= !dy1_reg[DIFF_W-1] && (dy1_reg != '0);
        gm2_reg  <= gravity_reg * m1_1_reg;
        m2_2_reg <= m2_1_reg;
        ow2_reg  <= ow1_reg;

        sqx3_reg <= adx2_reg * adx2_reg;
        sqy3_reg <= ady2_reg * ady2_reg;
        kl3_reg  <= gm2_reg[MASS_W-1:0] * m2_2_reg;
        kh3_reg  <= gm2_reg[GM_W-1:MASS_W] * m2_2_reg;
        adx3_reg <= adx2_reg;
        ady3_reg <= ady2_reg;
        px3_reg  <= px2_reg;
        py3_reg  <= py2_reg;
        ow3_reg  <= ow2_reg;

        side4_reg.s       <= SUM_W'(sqx3_reg) + SUM_W'(sqy3_reg);
        side4_reg.k       <= (K_W'(kh3_reg) << MASS_W) + K_W'(kl3_reg);
        side4_reg.adx     <= adx3_reg;
        side4_reg.ady     <= ady3_reg;
        side4_reg.px      <= px3_reg;
        side4_reg.py      <= py3_reg;
        side4_reg.one_way <= ow3_reg;
    end

    gpf_isqrt_pipe u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .rad       ({side4_reg.s, {(2 * EXTRA_BITS){1'b0}}}),
        .in_side   (side4_reg),
        .out_valid (sq_valid),
        .root      (rq),
        .out_side  (sq_side)
    );

    // Stage 5: minimum distance test and partial products.
    logic                       v5_reg;
    logic [S_LO_W+R_LO_W-1:0]   dp0_reg;
    logic [S_LO_W+R_HI_W-1:0]   dp1_reg;
    logic [S_HI_W+R_LO_W-1:0]   dp2_reg;
    logic [S_HI_W+R_HI_W-1:0]   dp3_reg;
    logic [SQR_W-1:0]           np5_reg [2][3];
    gpf_div_side_t              side5_reg;
    logic [ABS_W-1:0]           ad5 [2];
    logic                       close5_next;

    assign ad5[0] = sq_side.adx;
    assign ad5[1] = sq_side.ady;
    assign close5_next = rq[ROOT_W-1:EXTRA_BITS] < (ROOT_W - EXTRA_BITS)'(min_dist_reg);

    // Stage 6: sums into the divider.
    logic             v6_reg;
    logic [DEN_W-1:0] den6_reg;
    logic [NUM_W-1:0] num6_reg [2];
    gpf_div_side_t    side6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= sq_valid;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dp0_reg <= sq_side.s[S_LO_W-1:0] * rq[R_LO_W-1:0];
        dp1_reg <= sq_side.s[S_LO_W-1:0] * rq[ROOT_W-1:R_LO_W];
        dp2_reg <= sq_side.s[SUM_W-1:S_LO_W] * rq[R_LO_W-1:0];
        dp3_reg <= sq_side.s[SUM_W-1:S_LO_W] * rq[ROOT_W-1:R_LO_W];
        side5_reg.close   <= close5_next;
        side5_reg.kill    <= close5_next || (sq_side.s == '0);
        side5_reg.px      <= sq_side.px;
        side5_reg.py      <= sq_side.py;
        side5_reg.one_way <= sq_side.one_way;

        den6_reg  <= DEN_W'(dp0_reg)
                   + (DEN_W'(dp1_reg) << R_LO_W)
                   + (DEN_W'(dp2_reg) << S_LO_W)
                   + (DEN_W'(dp3_reg) << (S_LO_W + R_LO_W));
        side6_reg <= side5_reg;
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_num
        for (genvar i = 0; i < 3; i++)
        begin : g_part
            always_ff @(posedge clk)
            begin
                np5_reg[l][i] <= sq_side.k[MASS_W*i +: MASS_W] * ad5[l];
            end
        end

        always_ff @(posedge clk)
        begin
            num6_reg[l] <= {PROD_W'(np5_reg[l][0])
                            + (PROD_W'(np5_reg[l][1]) << MASS_W)
                            + (PROD_W'(np5_reg[l][2]) << (2 * MASS_W)),
                            {EXTRA_BITS{1'b0}}};
        end
    end

    logic             dv_valid;
    logic [MAG_W-1:0] mag_x, mag_y;
    logic             over_x, over_y;
    gpf_div_side_t    dv_side;

    gpf_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .num_x     (num6_reg[0]),
        .num_y     (num6_reg[1]),
        .den       (den6_reg),
        .in_side   (side6_reg),
        .out_valid (dv_valid),
        .mag_x     (mag_x),
        .mag_y     (mag_y),
        .over_x    (over_x),
        .over_y    (over_y),
        .out_side  (dv_side)
    );

    // Output stage: signs, zeroing and flags.
    logic [FORCE_W-1:0] magx_w, magy_w, negx_w, negy_w;
    logic               done_reg;
    gpf_out_t           forces_reg, forces_next;

    assign magx_w = {1'b0, mag_x};
    assign magy_w = {1'b0, mag_y};
    assign negx_w = FORCE_W'(0) - magx_w;
    assign negy_w = FORCE_W'(0) - magy_w;

    always_comb
    begin
        forces_next.second_applies = !dv_side.one_way;
        forces_next.too_close      = dv_side.close;
        if (dv_side.kill)
        begin
            forces_next.first_force_x  = '0;
            forces_next.first_force_y  = '0;
            forces_next.second_force_x = '0;
            forces_next.second_force_y = '0;
            forces_next.saturated      = 1'b0;
        end
        else
        begin
            forces_next.first_force_x  = dv_side.px ? magx_w : negx_w;
            forces_next.second_force_x = dv_side.px ? negx_w : magx_w;
            forces_next.first_force_y  = dv_side.py ? magy_w : negy_w;
            forces_next.second_force_y = dv_side.py ? negy_w : magy_w;
            forces_next.saturated      = over_x || over_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        forces_reg <= forces_next;
    end

    assign done   = done_reg;
    assign forces = forces_reg;

endmodule

// ----- src/gravity_pair_force_unit_chk.sv -----
// Port-level checker for the gravity pair force unit, bound to the top level.
// Depends on gpf_pkg and the assertion macros in gravity_pair_force_unit_assert.svh.
`include "gravity_pair_force_unit_assert.svh"

module gravity_pair_force_unit_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input gpf_pkg::gpf_out_t forces
);
    import gpf_pkg::*;

    `GPF_ASSERT_IMP(a_close_zero, done && forces.too_close, (forces.first_force_x == '0) && (forces.first_force_y == '0) && (forces.second_force_x == '0) && (forces.second_force_y == '0) && !forces.saturated)
    `GPF_ASSERT_IMP(a_negation, done, ((forces.first_force_x + forces.second_force_x) == '0) && ((forces.first_force_y + forces.second_force_y) == '0))
    `GPF_ASSERT_IMP(a_done_has_beat, done, $past(start && !busy, GPF_LATENCY))
    `GPF_ASSERT_NXT(a_beat_gives_done, $past(start && !busy, GPF_LATENCY - 1), done)

endmodule

bind gravity_pair_force_unit gravity_pair_force_unit_chk u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .forces (forces)
);
